>>> rtl/assert_macros.svh
// Assertion macros for the RTL files; the positional list engine includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check an implication on every rising clock edge outside reset.
`define PLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds on any rising clock edge outside reset.
`define PLE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PLE_ASSERT(lbl, prop, msg)
`define PLE_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/ple_pkg.sv
// Types, constants and helpers of the positional list engine.
package ple_pkg;

  localparam int CAPACITY    = 64;
  localparam int ENTRY_WIDTH = 32;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 7;
  localparam int COUNT_W     = 7;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_REM_HEAD = 3'd3,
    OP_REM_TAIL = 3'd4,
    OP_REM_POS  = 3'd5,
    OP_READ_POS = 3'd6
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_REM_CAP,
    S_REM,
    S_RD_CAP
  } state_e;

  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [ENTRY_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]      raddr;
  } mem_req_t;

  function automatic logic [ENTRY_WIDTH-1:0] to_entry(logic [VALUE_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[ENTRY_WIDTH-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] from_entry(logic [ENTRY_WIDTH-1:0] e);
    logic [63:0] w;
    w = 64'(e);
    return w[VALUE_W-1:0];
  endfunction

endpackage

>>> rtl/ple_mem.sv
// Entry store: one write port, one read port with registered read data.
module ple_mem
  import ple_pkg::*;
(
  input  logic                   clk_i,
  input  mem_req_t               req_i,
  output logic [ENTRY_WIDTH-1:0] rdata_o
);

  logic [ENTRY_WIDTH-1:0] mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

>>> rtl/positional_list_engine.sv
// Positional list engine: bounded ordered list of handles kept in one memory.
//
// Command channel: drive opcode_i, position_i and entry_value_i with start_i;
// the command is taken at a rising edge where start_i is high and busy_o low.
// Result channel: result_valid_o is high for exactly one cycle with
// result_value_o, status_o and entry_count_o; the receiver cannot stall it.
// A rejected command or unused opcode answers in the cycle after it is
// taken and leaves busy_o low. A read captures the addressed entry in
// S_RD_CAP, then answers. Each moved entry passes through the single read
// port and single write port of the entry memory, and the last moved entry
// is drained before the result. An insert at position p into a list of n
// entries moves the n - p entries from p up; a removal at p moves the
// entries above p down. One command is in flight at a time; busy_o stays
// high until its result is shown.
// Reset empties the list; the memory itself is not cleared, since only
// entries below the count are ever read.
`include "assert_macros.svh"
module positional_list_engine
  import ple_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         opcode_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [VALUE_W-1:0] entry_value_i,
  output logic               result_valid_o,
  output logic [VALUE_W-1:0] result_value_o,
  output logic [1:0]         status_o,
  output logic [COUNT_W-1:0] entry_count_o
);

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   done_q, done_d;
  logic                   pend_q, pend_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       pos_q, pos_d;
  logic [ADDR_W-1:0]      wa_q, wa_d;
  logic [ENTRY_WIDTH-1:0] val_q, val_d;
  logic [ENTRY_WIDTH-1:0] res_q, res_d;
  logic [VALUE_W-1:0]     out_val_q, out_val_d;
  status_e                out_st_q, out_st_d;

  mem_req_t               mem_req;
  logic [ENTRY_WIDTH-1:0] mem_rdata;

  logic [CMP_W-1:0]       pos_ext, cnt_ext, ins_p, rem_p;
  logic                   accept;

  ple_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign accept  = start_i && (state_q == S_IDLE);
  assign pos_ext = CMP_W'(position_i);
  assign cnt_ext = CMP_W'(count_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    done_d    = 1'b0;
    pend_d    = pend_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    wa_d      = wa_q;
    val_d     = val_q;
    res_d     = res_q;
    out_val_d = out_val_q;
    out_st_d  = out_st_q;
    mem_req   = '{we: 1'b0, waddr: wa_q, wdata: mem_rdata, raddr: idx_q[ADDR_W-1:0]};
    ins_p     = '0;
    rem_p     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_val_d = '0;
          out_st_d  = ST_OK;
          val_d     = to_entry(entry_value_i);
          pend_d    = 1'b0;
          unique case (opcode_i)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
              ins_p = (opcode_i == OP_INS_HEAD) ? '0 :
                      (opcode_i == OP_INS_TAIL) ? cnt_ext : pos_ext;
              if (ins_p > cnt_ext) begin
                out_st_d = ST_RANGE;
                done_d   = 1'b1;
              end else if (count_q == CNT_W'(CAPACITY)) begin
                out_st_d = ST_FULL;
                done_d   = 1'b1;
              end else begin
                pos_d   = ins_p[CNT_W-1:0];
                idx_d   = count_q;
                state_d = S_INS;
              end
            end
            OP_REM_HEAD, OP_REM_TAIL, OP_REM_POS: begin
              rem_p = (opcode_i == OP_REM_HEAD) ? '0 :
                      (opcode_i == OP_REM_TAIL) ? cnt_ext - CMP_W'(1) : pos_ext;
              if (count_q == '0) begin
                out_st_d = ST_EMPTY;
                done_d   = 1'b1;
              end else if (rem_p >= cnt_ext) begin
                out_st_d = ST_RANGE;
                done_d   = 1'b1;
              end else begin
                pos_d         = rem_p[CNT_W-1:0];
                mem_req.raddr = rem_p[ADDR_W-1:0];
                state_d       = S_REM_CAP;
              end
            end
            OP_READ_POS: begin
              if (pos_ext >= cnt_ext) begin
                out_st_d = ST_RANGE;
                done_d   = 1'b1;
              end else begin
                mem_req.raddr = position_i[ADDR_W-1:0];
                state_d       = S_RD_CAP;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_INS: begin
        // Walk down from the tail: read i-1, write it to i the cycle after.
        if (pend_q) begin
          mem_req.we = 1'b1;
        end
        if (idx_q > pos_q) begin
          mem_req.raddr = ADDR_W'(idx_q - CNT_W'(1));
          wa_d          = idx_q[ADDR_W-1:0];
          pend_d        = 1'b1;
          idx_d         = idx_q - CNT_W'(1);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_q[ADDR_W-1:0];
          mem_req.wdata = val_q;
          count_d       = count_q + CNT_W'(1);
          done_d        = 1'b1;
          state_d       = S_IDLE;
        end
      end

      S_REM_CAP: begin
        res_d   = mem_rdata;
        idx_d   = pos_q;
        pend_d  = 1'b0;
        state_d = S_REM;
      end

      S_REM: begin
        // Walk up from the gap: read i+1, write it to i the cycle after.
        if (pend_q) begin
          mem_req.we = 1'b1;
        end
        if ((idx_q + CNT_W'(1)) < count_q) begin
          mem_req.raddr = ADDR_W'(idx_q + CNT_W'(1));
          wa_d          = idx_q[ADDR_W-1:0];
          pend_d        = 1'b1;
          idx_d         = idx_q + CNT_W'(1);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          count_d   = count_q - CNT_W'(1);
          out_val_d = from_entry(res_q);
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_RD_CAP: begin
        out_val_d = from_entry(mem_rdata);
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    wa_q      <= wa_d;
    val_q     <= val_d;
    res_q     <= res_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = done_q;
  assign result_value_o = out_val_q;
  assign status_o       = out_st_q;
  assign entry_count_o  = COUNT_W'(count_q);

  `PLE_ASSERT(a_err_zero, done_q && out_st_q != ST_OK |-> out_val_q == '0, "error result not zero")
  `PLE_ASSERT_NEVER(a_cnt_cap, count_q > CNT_W'(CAPACITY), "count beyond capacity")
  `PLE_ASSERT(a_cnt_with_result, !$stable(count_q) |-> done_q, "count moved without a result")
  `PLE_ASSERT(a_full_cnt, done_q && out_st_q == ST_FULL |-> count_q == CNT_W'(CAPACITY),
              "full flagged below capacity")
  `PLE_ASSERT(a_we_busy, mem_req.we |-> state_q != S_IDLE, "memory write while idle")

endmodule
